[hdl/pjs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pjs_pkg: shared types and codes for the program-jog sequencer
// Status, drive command, host command, sequence step and pattern codes, plus
// the structs passed between the register file, step logic and top level.
// ----------------------------------------------------------------------------
package pjs_pkg;

  // Field widths
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned DCMD_W    = 2;
  localparam int unsigned HCMD_W    = 2;
  localparam int unsigned PTR_W     = 3;
  localparam int unsigned PAT_W     = 4;
  localparam int unsigned DIST_W    = 31;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 31;

  // Jog status codes
  localparam logic [STATUS_W-1:0] ST_INIT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RUN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_END   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABORT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ERROR = 3'd4;

  // Host command codes
  localparam logic [HCMD_W-1:0] HC_NONE  = 2'd0;
  localparam logic [HCMD_W-1:0] HC_INIT  = 2'd1;
  localparam logic [HCMD_W-1:0] HC_START = 2'd2;
  localparam logic [HCMD_W-1:0] HC_ABORT = 2'd3;

  // Drive command codes
  localparam logic [DCMD_W-1:0] DC_INIT  = 2'd0;
  localparam logic [DCMD_W-1:0] DC_START = 2'd1;
  localparam logic [DCMD_W-1:0] DC_ABORT = 2'd2;

  // Sequence step codes
  localparam logic [PTR_W-1:0] SP_IDLE       = 3'd0;
  localparam logic [PTR_W-1:0] SP_WAIT_FIRST = 3'd1;
  localparam logic [PTR_W-1:0] SP_MOVING     = 3'd2;
  localparam logic [PTR_W-1:0] SP_COUNT      = 3'd3;
  localparam logic [PTR_W-1:0] SP_WAIT_NEXT  = 3'd4;
  localparam logic [PTR_W-1:0] SP_FINISH     = 3'd5;
  localparam logic [PTR_W-1:0] SP_ABORT      = 3'd6;
  localparam logic [PTR_W-1:0] SP_ERROR      = 3'd7;

  // Direction pattern codes; anything from PAT_SINGLE up is a single move
  localparam logic [PAT_W-1:0] PAT_FWD      = 4'd0;
  localparam logic [PAT_W-1:0] PAT_REV      = 4'd1;
  localparam logic [PAT_W-1:0] PAT_HALF_FWD = 4'd2;
  localparam logic [PAT_W-1:0] PAT_HALF_REV = 4'd3;
  localparam logic [PAT_W-1:0] PAT_ALT_FWD  = 4'd4;
  localparam logic [PAT_W-1:0] PAT_ALT_REV  = 4'd5;
  localparam logic [PAT_W-1:0] PAT_SINGLE   = 4'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_JOG_PATTERN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DISTANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TIMES    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MS       = 2'd3;

  typedef struct packed {
    logic [PAT_W-1:0]   jog_pattern;
    logic [DIST_W-1:0]  move_distance;
    logic [COUNT_W-1:0] move_times;
    logic [WAIT_W-1:0]  wait_ms;
  } cfg_t;

  typedef struct packed {
    logic               jog_mode_active;
    logic [HCMD_W-1:0]  host_command;
    logic               alarm_active;
    logic               safety_block;
    logic               main_power_on;
    logic               overtravel;
    logic               base_enabled;
    logic               move_done;
    logic [TIME_W-1:0]  now_ms;
  } scan_t;

  typedef struct packed {
    logic [PTR_W-1:0]    step_pointer;
    logic [STATUS_W-1:0] status;
    logic [DCMD_W-1:0]   command;
    logic [COUNT_W-1:0]  move_counter;
    logic [TIME_W-1:0]   wait_start_ms;
    logic [POS_W-1:0]    target;
  } seq_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] jog_status;
    logic [DCMD_W-1:0]   drive_command;
    logic [POS_W-1:0]    position_target;
    logic                motion_reset;
  } result_t;

endpackage
`default_nettype wire

[hdl/pjs_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pjs_cfg_regs: configuration register file
// Decodes the write port into the four jog settings and holds them.
// ----------------------------------------------------------------------------
module pjs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [pjs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pjs_pkg::CFG_DW-1:0]    cfg_data,
  output pjs_pkg::cfg_t                      cfg
);
  import pjs_pkg::*;

  // Register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_JOG_PATTERN:   cfg.jog_pattern   <= cfg_data[PAT_W-1:0];
        CFG_MOVE_DISTANCE: cfg.move_distance <= cfg_data[DIST_W-1:0];
        CFG_MOVE_TIMES:    cfg.move_times    <= cfg_data[COUNT_W-1:0];
        CFG_WAIT_MS:       cfg.wait_ms       <= cfg_data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/pjs_step_logic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pjs_step_logic: one control scan of the jog sequence
// Fault/abort/init overrides, then one step of the eight-step sequence.
// Pure combinational; the caller registers state and result.
// ----------------------------------------------------------------------------
module pjs_step_logic (
  input  wire pjs_pkg::cfg_t       cfg,
  input  wire pjs_pkg::scan_t      scan,
  input  wire pjs_pkg::seq_state_t cur,
  output pjs_pkg::seq_state_t      nxt,
  output pjs_pkg::result_t         res
);
  import pjs_pkg::*;

  logic               running;
  logic               fault;
  logic [TIME_W-1:0]  elapsed;
  logic               wait_done;
  logic [COUNT_W-1:0] count_inc;
  logic               first_half;
  logic               odd_move;
  logic [POS_W-1:0]   stride;
  logic               mreset;
  logic [PTR_W-1:0]   ptr;

  // Shared terms
  assign running    = (cur.status == ST_RUN);
  assign fault      = scan.alarm_active | scan.safety_block | ~scan.main_power_on |
                      (running & scan.overtravel);
  assign elapsed    = scan.now_ms - cur.wait_start_ms;
  assign wait_done  = (elapsed >= {{(TIME_W-WAIT_W){1'b0}}, cfg.wait_ms});
  assign count_inc  = cur.move_counter + {{(COUNT_W-1){1'b0}}, 1'b1};
  assign first_half = (cur.move_counter < {1'b0, cfg.move_times[COUNT_W-1:1]});
  assign odd_move   = cur.move_counter[0];
  assign stride     = {{(POS_W-DIST_W){1'b0}}, cfg.move_distance};

  // Overrides, then sequence step
  always_comb begin
    nxt    = cur;
    mreset = 1'b0;
    ptr    = cur.step_pointer;
    if (scan.jog_mode_active) begin
      if (fault) begin
        ptr = SP_ERROR;
      end else if (scan.host_command == HC_ABORT) begin
        ptr = SP_ABORT;
      end else if (running && !scan.base_enabled) begin
        ptr = SP_ABORT;
      end
      // Init wins over any fault or abort found in the same scan
      if (scan.host_command == HC_INIT) begin
        ptr         = SP_IDLE;
        nxt.command = DC_INIT;
        nxt.status  = ST_INIT;
      end
      nxt.step_pointer = ptr;

      unique case (ptr)
        SP_IDLE: begin
          if (scan.host_command == HC_START && scan.base_enabled) begin
            nxt.move_counter  = '0;
            nxt.wait_start_ms = scan.now_ms;
            nxt.status        = ST_RUN;
            // Split patterns cannot run endless
            if (cfg.move_times == '0 &&
                (cfg.jog_pattern == PAT_HALF_FWD || cfg.jog_pattern == PAT_HALF_REV)) begin
              nxt.step_pointer = SP_ERROR;
            end else begin
              nxt.step_pointer = SP_WAIT_FIRST;
            end
          end
        end
        SP_WAIT_FIRST: begin
          if (wait_done) begin
            mreset           = 1'b1;
            nxt.command      = DC_START;
            nxt.target       = cfg.jog_pattern[0] ? (POS_W'(0) - stride) : stride;
            nxt.step_pointer = SP_MOVING;
          end
        end
        SP_MOVING: begin
          if (scan.move_done) begin
            nxt.step_pointer = SP_COUNT;
          end
        end
        SP_COUNT: begin
          nxt.move_counter = count_inc;
          if (count_inc >= cfg.move_times && cfg.move_times != '0) begin
            nxt.step_pointer = SP_FINISH;
          end else begin
            nxt.wait_start_ms = scan.now_ms;
            nxt.step_pointer  = SP_WAIT_NEXT;
          end
        end
        SP_WAIT_NEXT: begin
          if (wait_done) begin
            // Direction of the next move per pattern
            case (cfg.jog_pattern)
              PAT_FWD:      nxt.target = cur.target + stride;
              PAT_REV:      nxt.target = cur.target - stride;
              PAT_HALF_FWD: nxt.target = first_half ? cur.target + stride : cur.target - stride;
              PAT_HALF_REV: nxt.target = first_half ? cur.target - stride : cur.target + stride;
              PAT_ALT_FWD:  nxt.target = odd_move ? cur.target - stride : cur.target + stride;
              PAT_ALT_REV:  nxt.target = odd_move ? cur.target + stride : cur.target - stride;
              default:      nxt.target = cur.target;
            endcase
            nxt.step_pointer = (cfg.jog_pattern < PAT_SINGLE) ? SP_MOVING : SP_FINISH;
          end
        end
        SP_FINISH: begin
          nxt.status       = ST_END;
          nxt.command      = DC_INIT;
          nxt.step_pointer = SP_IDLE;
        end
        SP_ABORT: begin
          mreset           = 1'b1;
          nxt.target       = '0;
          nxt.command      = DC_ABORT;
          nxt.status       = ST_ABORT;
          nxt.step_pointer = SP_IDLE;
        end
        default: begin
          mreset           = 1'b1;
          nxt.target       = '0;
          nxt.command      = DC_ABORT;
          nxt.status       = ST_ERROR;
          nxt.step_pointer = SP_IDLE;
        end
      endcase
    end
  end

  // Result of this scan
  assign res.jog_status      = nxt.status;
  assign res.drive_command   = nxt.command;
  assign res.position_target = nxt.target;
  assign res.motion_reset    = mreset;

endmodule
`default_nettype wire

[hdl/program_jog_sequencer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// program_jog_sequencer_top: servo program-jog sequencer
// One control scan in, one status/command/target result out.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------------
//   cfg       cfg_write              cfg_index, cfg_data
//   in        in_valid / in_ready    jog_mode_active .. now_ms
//   out       out_valid / out_ready  jog_status, drive_command,
//                                    position_target, motion_reset
//
// A scan lands in the input register, is evaluated by the step logic and its
// result is loaded into the output register together with the sequence state
// once the output slot frees or drains; one scan per cycle sustained while
// out_ready is high. While a result waits on out_ready the input register
// takes at most one more scan, then in_ready drops until the output drains.
// rst is synchronous and clears the sequence state and both valid flags.
// ----------------------------------------------------------------------------
module program_jog_sequencer_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write port
  input  wire logic                               cfg_write,
  input  wire logic [pjs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pjs_pkg::CFG_DW-1:0]         cfg_data,
  // Scan input
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               jog_mode_active,
  input  wire logic [pjs_pkg::HCMD_W-1:0]         host_command,
  input  wire logic                               alarm_active,
  input  wire logic                               safety_block,
  input  wire logic                               main_power_on,
  input  wire logic                               overtravel,
  input  wire logic                               base_enabled,
  input  wire logic                               move_done,
  input  wire logic [pjs_pkg::TIME_W-1:0]         now_ms,
  // Result output
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [pjs_pkg::STATUS_W-1:0]            jog_status,
  output logic [pjs_pkg::DCMD_W-1:0]              drive_command,
  output logic signed [pjs_pkg::POS_W-1:0]        position_target,
  output logic                                    motion_reset
);
  import pjs_pkg::*;

  cfg_t       cfg;
  scan_t      scan_q;
  logic       scan_valid;
  seq_state_t state;
  seq_state_t state_next;
  result_t    res_next;
  result_t    res_q;
  logic       advance;

  pjs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pjs_step_logic u_step (
    .cfg  (cfg),
    .scan (scan_q),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Flow control: a held scan moves on when the output slot is free or draining
  assign advance  = scan_valid && (!out_valid || out_ready);
  assign in_ready = !scan_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (in_ready) begin
      scan_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      scan_q.jog_mode_active <= jog_mode_active;
      scan_q.host_command    <= host_command;
      scan_q.alarm_active    <= alarm_active;
      scan_q.safety_block    <= safety_block;
      scan_q.main_power_on   <= main_power_on;
      scan_q.overtravel      <= overtravel;
      scan_q.base_enabled    <= base_enabled;
      scan_q.move_done       <= move_done;
      scan_q.now_ms          <= now_ms;
    end
  end

  // Sequence state, updated once per evaluated scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign jog_status      = res_q.jog_status;
  assign drive_command   = res_q.drive_command;
  assign position_target = $signed(res_q.position_target);
  assign motion_reset    = res_q.motion_reset;

  // Checks
  a_reset_has_command: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion_reset |-> drive_command != DC_INIT)
    else $error("motion reset without start or abort command");

  a_abort_clears_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && motion_reset && drive_command == DC_ABORT |-> position_target == '0)
    else $error("abort left a nonzero target");

  a_mode_off_holds: assert property (@(posedge clk) disable iff (rst)
    advance && !scan_q.jog_mode_active |=> $stable(state))
    else $error("sequence state moved with jog mode off");

  a_empty_out_takes_scan: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    $past(advance) |-> jog_status == state.status && drive_command == state.command)
    else $error("result disagrees with sequence state");

endmodule
`default_nettype wire
